>>> hdl/dpxp_pkg.sv
// ----------------------------------------------------------------------------
// dpxp_pkg
// Shared types and constants for the dual-window XRAM portal with byte stack.
// ----------------------------------------------------------------------------
package dpxp_pkg;

  // Storage sizing
  localparam int RAM_ADDR_BITS  = 16;
  localparam int STACK_DEPTH    = 512;
  localparam int STACK_IDX_BITS = $clog2(STACK_DEPTH);
  localparam int STACK_POS_BITS = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 4;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic REG_STEP_PORT0 = 1'b0;
  localparam logic REG_STEP_PORT1 = 1'b1;
  localparam logic [BYTE_W-1:0] STEP_RESET = 8'd1;

  // Bus access modes
  localparam logic [MODE_W-1:0] MODE_W0_ADDR_HI = 4'd0;
  localparam logic [MODE_W-1:0] MODE_W0_ADDR_LO = 4'd1;
  localparam logic [MODE_W-1:0] MODE_W0_WRITE   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_W0_READ    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_W1_ADDR_HI = 4'd4;
  localparam logic [MODE_W-1:0] MODE_W1_ADDR_LO = 4'd5;
  localparam logic [MODE_W-1:0] MODE_W1_WRITE   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_W1_READ    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_PUSH       = 4'd8;
  localparam logic [MODE_W-1:0] MODE_POP        = 4'd9;
  localparam logic [MODE_W-1:0] MODE_STACK_RST  = 4'd10;

  // Window step settings handed from the register block to the core
  typedef struct packed {
    logic [BYTE_W-1:0] step_port0;
    logic [BYTE_W-1:0] step_port1;
  } cfg_t;

  // Address plus sign-extended step, wrapping at 16 bits
  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] addr,
                                                input logic [BYTE_W-1:0] step);
    advance = addr + {{(ADDR_W-BYTE_W){step[BYTE_W-1]}}, step};
  endfunction

endpackage

>>> hdl/dpxp_ram.sv
// ----------------------------------------------------------------------------
// dpxp_ram
// Generic synchronous RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dpxp_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 8,
  parameter int DEPTH     = 65536
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Read returns the old contents on a same-cycle collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/dpxp_regs.sv
// ----------------------------------------------------------------------------
// dpxp_regs
// APB register block holding the two signed window step settings.
// ----------------------------------------------------------------------------
module dpxp_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dpxp_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [dpxp_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [dpxp_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output dpxp_pkg::cfg_t                       cfg
);

  logic wr_xfer;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_xfer = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_port0 <= dpxp_pkg::STEP_RESET;
      cfg.step_port1 <= dpxp_pkg::STEP_RESET;
    end else if (wr_xfer) begin
      if (reg_sel == dpxp_pkg::REG_STEP_PORT0) begin
        cfg.step_port0 <= pwdata[dpxp_pkg::BYTE_W-1:0];
      end else begin
        cfg.step_port1 <= pwdata[dpxp_pkg::BYTE_W-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (reg_sel == dpxp_pkg::REG_STEP_PORT0) begin
      prdata = dpxp_pkg::CFG_DATA_BITS'(cfg.step_port0);
    end else begin
      prdata = dpxp_pkg::CFG_DATA_BITS'(cfg.step_port1);
    end
  end

endmodule

>>> hdl/dual_port_xram_portal_with_byte_stack_core.sv
// ----------------------------------------------------------------------------
// dual_port_xram_portal_with_byte_stack_core
// Two address windows into extended RAM plus a downward-growing byte stack.
// ----------------------------------------------------------------------------
// For each accepted item the transfer cycle writes RAM or stack and issues
// the reads at the updated window addresses and stack position; the
// registered read data then land in the output register once it is free.
// No new item is taken while an earlier item's read data are pending. A new item is
// taken while a finished result waits on the output. After reset the RAM is
// swept to zero, one byte a cycle, over all 2^RAM_ADDR_BITS addresses (65536
// at the default size); in_ready stays low during that sweep while the APB
// port remains usable. Window writes forward the written byte to a read of the
// same location, so both latches show it when the windows alias.
module dual_port_xram_portal_with_byte_stack_core (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dpxp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dpxp_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dpxp_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpxp_pkg::MODE_W-1:0]         mode,
  input  logic [dpxp_pkg::BYTE_W-1:0]         data,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dpxp_pkg::BYTE_W-1:0]         latch_port0,
  output logic [dpxp_pkg::BYTE_W-1:0]         latch_port1,
  output logic [dpxp_pkg::BYTE_W-1:0]         stack_top,
  output logic                                mirror_valid,
  output logic [dpxp_pkg::ADDR_W-1:0]         mirror_addr,
  output logic [dpxp_pkg::BYTE_W-1:0]         mirror_data
);

  localparam int RB = dpxp_pkg::RAM_ADDR_BITS;
  localparam int IB = dpxp_pkg::STACK_IDX_BITS;
  localparam int PB = dpxp_pkg::STACK_POS_BITS;
  localparam int AW = dpxp_pkg::ADDR_W;
  localparam int BW = dpxp_pkg::BYTE_W;
  localparam logic [PB-1:0] POS_EMPTY = PB'(dpxp_pkg::STACK_DEPTH);

  dpxp_pkg::cfg_t cfg;

  // Window and stack state
  logic [AW-1:0] addr0, addr0_next;
  logic [AW-1:0] addr1, addr1_next;
  logic [PB-1:0] pos, pos_next;

  // Clearing sweep
  logic          clearing;
  logic [RB-1:0] clr_cnt;

  // Per-item control captured at the transfer
  logic          rd_pend;
  logic          fwd0, fwd1, fwd_s, st_empty;
  logic          m_valid;
  logic [AW-1:0] m_addr;
  logic [BW-1:0] wbyte;

  logic          acc, out_load;
  logic          wr_en, is_w0_wr, is_w1_wr, push_ok, pop_ok;
  logic [RB-1:0] wr_idx;
  logic          ram_we;
  logic [RB-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic [BW-1:0] rd0, rd1, rds;
  logic [IB-1:0] st_widx;

  dpxp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake
  assign in_ready = ~clearing & ~rd_pend;
  assign acc      = in_valid & in_ready;
  assign out_load = rd_pend & (~out_valid | out_ready);

  // Next window addresses and stack position
  always_comb begin
    addr0_next = addr0;
    addr1_next = addr1;
    pos_next   = pos;
    case (mode)
      dpxp_pkg::MODE_W0_ADDR_HI: addr0_next = {data, addr0[BW-1:0]};
      dpxp_pkg::MODE_W0_ADDR_LO: addr0_next = {addr0[AW-1:BW], data};
      dpxp_pkg::MODE_W0_WRITE,
      dpxp_pkg::MODE_W0_READ:    addr0_next = dpxp_pkg::advance(addr0, cfg.step_port0);
      dpxp_pkg::MODE_W1_ADDR_HI: addr1_next = {data, addr1[BW-1:0]};
      dpxp_pkg::MODE_W1_ADDR_LO: addr1_next = {addr1[AW-1:BW], data};
      dpxp_pkg::MODE_W1_WRITE,
      dpxp_pkg::MODE_W1_READ:    addr1_next = dpxp_pkg::advance(addr1, cfg.step_port1);
      dpxp_pkg::MODE_PUSH: begin
        if (push_ok) pos_next = pos - PB'(1);
      end
      dpxp_pkg::MODE_POP: begin
        if (pop_ok) pos_next = pos + PB'(1);
      end
      dpxp_pkg::MODE_STACK_RST:  pos_next = POS_EMPTY;
      default: ;
    endcase
  end

  // Write decode
  assign is_w0_wr = (mode == dpxp_pkg::MODE_W0_WRITE);
  assign is_w1_wr = (mode == dpxp_pkg::MODE_W1_WRITE);
  assign wr_en    = is_w0_wr | is_w1_wr;
  assign wr_idx   = is_w0_wr ? addr0[RB-1:0] : addr1[RB-1:0];
  assign push_ok  = (pos != '0);
  assign pop_ok   = (pos != POS_EMPTY);
  assign st_widx  = pos_next[IB-1:0];

  // RAM write port: clearing sweep or a window write
  assign ram_we    = clearing | (acc & wr_en);
  assign ram_waddr = clearing ? clr_cnt : wr_idx;
  assign ram_wdata = clearing ? '0 : data;

  // Replicated RAM gives one read port per window
  dpxp_ram #(.ADDR_BITS(RB), .DATA_BITS(BW), .DEPTH(1 << RB)) u_ram0 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (addr0_next[RB-1:0]),
    .rdata (rd0)
  );

  dpxp_ram #(.ADDR_BITS(RB), .DATA_BITS(BW), .DEPTH(1 << RB)) u_ram1 (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (addr1_next[RB-1:0]),
    .rdata (rd1)
  );

  // Stack memory: push writes the new top, read follows the new position
  dpxp_ram #(.ADDR_BITS(IB), .DATA_BITS(BW), .DEPTH(dpxp_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (acc & (mode == dpxp_pkg::MODE_PUSH) & push_ok),
    .waddr (st_widx),
    .wdata (data),
    .re    (acc),
    .raddr (st_widx),
    .rdata (rds)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      addr0    <= '0;
      addr1    <= '0;
      pos      <= POS_EMPTY;
      clearing <= 1'b1;
      clr_cnt  <= '0;
      rd_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Zero sweep after reset
      if (clearing) begin
        clr_cnt <= clr_cnt + RB'(1);
        if (clr_cnt == '1) clearing <= 1'b0;
      end
      if (acc) begin
        addr0 <= addr0_next;
        addr1 <= addr1_next;
        pos   <= pos_next;
      end
      if (acc) begin
        rd_pend <= 1'b1;
      end else if (out_load) begin
        rd_pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Forwarding flags and mirror event captured at the transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      fwd0     <= wr_en & (addr0_next[RB-1:0] == wr_idx);
      fwd1     <= wr_en & (addr1_next[RB-1:0] == wr_idx);
      fwd_s    <= (mode == dpxp_pkg::MODE_PUSH) & push_ok;
      st_empty <= (pos_next == POS_EMPTY);
      wbyte    <= data;
      m_valid  <= wr_en;
      m_addr   <= wr_en ? AW'(wr_idx) : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      latch_port0  <= fwd0 ? wbyte : rd0;
      latch_port1  <= fwd1 ? wbyte : rd1;
      stack_top    <= st_empty ? '0 : (fwd_s ? wbyte : rds);
      mirror_valid <= m_valid;
      mirror_addr  <= m_addr;
      mirror_data  <= m_valid ? wbyte : '0;
    end
  end

endmodule
